>>> design/cleb_pkg.sv
// ----------------------------------------------------------------------------
// cleb_pkg: shared types and constants for the console line edit buffer
// Key codes, command classes, the queue entry and the result record.
// ----------------------------------------------------------------------------
package cleb_pkg;

  localparam int DEFAULT_BUF_DEPTH = 128;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [7:0] KEY_NUL    = 8'h00;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_MENU   = 8'h07;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_LF     = 8'h0a;
  localparam logic [7:0] KEY_CR     = 8'h0d;
  localparam logic [7:0] KEY_CTRL_P = 8'h10;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_DEL    = 8'h7f;
  localparam logic [7:0] KEY_UP_W   = 8'h77;
  localparam logic [7:0] KEY_DOWN_S = 8'h73;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    CMD_DUMP,
    CMD_KILL,
    CMD_ERASE,
    CMD_TOGGLE,
    CMD_CHAR,
    CMD_READ
  } cmd_kind_t;

  // one classified request waiting for the back end
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] char_code;  // CR already folded to LF
    logic       is_zero;
    logic       is_w;
    logic       is_s;
    logic       is_commit;  // LF or Ctrl-D
    logic       started;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // first member lands in the highest bits
  typedef struct packed {
    logic [1:0] menu_row;
    logic       menu_active;
    logic       read_empty;
    logic       read_eof;
    logic       read_valid;
    logic [7:0] read_char;
    logic       dump_request;
    logic       wake_reader;
    logic [7:0] erase_count;
    logic       echo_valid;
    logic [7:0] echo_char;
  } res_t;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

endpackage

>>> design/cleb_front.sv
// ----------------------------------------------------------------------------
// cleb_front: request intake and classification
// Decodes each accepted request into a command class and pushes it.
// ----------------------------------------------------------------------------
module cleb_front
  import cleb_pkg::*;
(
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,  // key_code[7:0], read_started[8]
  input  logic                 in_tuser,  // op
  input  q_stat_t              q_stat,
  output logic                 push,
  output cmd_t                 push_cmd
);

  logic [7:0] key;
  logic [7:0] mapped;

  // queue backpressure and reset only; no local storage
  assign in_tready = rst_n && !q_stat.full;
  assign push      = in_tvalid && in_tready;

  assign key    = in_tdata[7:0];
  assign mapped = (key == KEY_CR) ? KEY_LF : key;

  always_comb begin
    push_cmd           = '0;
    push_cmd.char_code = mapped;
    push_cmd.is_zero   = (key == KEY_NUL);
    push_cmd.is_w      = (key == KEY_UP_W);
    push_cmd.is_s      = (key == KEY_DOWN_S);
    push_cmd.is_commit = (mapped == KEY_LF) || (mapped == KEY_CTRL_D);
    push_cmd.started   = in_tdata[8];
    if (in_tuser == OP_READ) begin
      push_cmd.kind = CMD_READ;
    end else if (key == KEY_CTRL_P) begin
      push_cmd.kind = CMD_DUMP;
    end else if (key == KEY_CTRL_U) begin
      push_cmd.kind = CMD_KILL;
    end else if (key == KEY_CTRL_H || key == KEY_DEL) begin
      push_cmd.kind = CMD_ERASE;
    end else if (key == KEY_MENU) begin
      push_cmd.kind = CMD_TOGGLE;
    end else begin
      push_cmd.kind = CMD_CHAR;
    end
  end

endmodule

>>> design/cleb_queue.sv
// ----------------------------------------------------------------------------
// cleb_queue: short command queue
// Decouples intake from execution so each side stalls on its own.
// ----------------------------------------------------------------------------
module cleb_queue
  import cleb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t q_stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t             store_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CNT_FULL);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> design/cleb_back.sv
// ----------------------------------------------------------------------------
// cleb_back: line buffer execution
// Owns the character ring and its indices, runs the kill-line scan and
// holds the result register.
// ----------------------------------------------------------------------------
module cleb_back
  import cleb_pkg::*;
#(
  parameter int BUF_DEPTH = DEFAULT_BUF_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_stat_t q_stat,
  input  cmd_t    head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output res_t    out_res
);

  localparam int SLOT_W = $clog2(BUF_DEPTH);
  localparam int POS_W  = SLOT_W + 1;
  localparam logic [POS_W-1:0] DEPTH_V  = POS_W'(BUF_DEPTH);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(2 * BUF_DEPTH - 1);
  localparam logic [POS_W:0]   POS_MOD  = (POS_W + 1)'(2 * BUF_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_KILL
  } state_t;

  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] x);
    return (x == POS_LAST) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [POS_W-1:0] pos_dec(input logic [POS_W-1:0] x);
    return (x == '0) ? POS_LAST : x - 1'b1;
  endfunction

  function automatic logic [POS_W-1:0] pos_dist(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    logic [POS_W:0] t;
    if (a >= b) begin
      t = {1'b0, a} - {1'b0, b};
    end else begin
      t = {1'b0, a} + POS_MOD - {1'b0, b};
    end
    return t[POS_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot(input logic [POS_W-1:0] x);
    logic [POS_W-1:0] s;
    s = (x >= DEPTH_V) ? x - DEPTH_V : x;
    return s[SLOT_W-1:0];
  endfunction

  logic [7:0]       ring_r [BUF_DEPTH];
  logic [7:0]       rd_data_r;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] read_idx_r, read_idx_nxt;
  logic [POS_W-1:0] commit_idx_r, commit_idx_nxt;
  logic [POS_W-1:0] edit_idx_r, edit_idx_nxt;
  logic             menu_r, menu_nxt;
  logic [1:0]       sel_r, sel_nxt;
  logic             started_r, started_nxt;
  logic [7:0]       erase_r, erase_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;

  logic              can_out;
  logic              we;
  logic [SLOT_W-1:0] wa;
  logic [7:0]        wd;
  logic [SLOT_W-1:0] ra;
  logic [POS_W-1:0]  edit_dec;
  logic [POS_W-1:0]  edit_inc;
  logic [7:0]        erase_sat;

  assign can_out   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign edit_dec  = pos_dec(edit_idx_r);
  assign edit_inc  = pos_inc(edit_idx_r);
  assign erase_sat = (erase_r == 8'hff) ? erase_r : erase_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    read_idx_nxt   = read_idx_r;
    commit_idx_nxt = commit_idx_r;
    edit_idx_nxt   = edit_idx_r;
    menu_nxt       = menu_r;
    sel_nxt        = sel_r;
    started_nxt    = started_r;
    erase_nxt      = erase_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    res_nxt        = res_r;
    pop            = 1'b0;
    we             = 1'b0;
    wa             = slot(edit_idx_r);
    wd             = head.char_code;
    ra             = slot(read_idx_r);

    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty && can_out) begin
          pop                 = 1'b1;
          res_nxt             = '0;
          res_nxt.menu_active = menu_r;
          res_nxt.menu_row    = sel_r;
          out_valid_nxt       = 1'b1;
          case (head.kind)
            CMD_DUMP: begin
              res_nxt.dump_request = 1'b1;
            end
            CMD_KILL: begin
              if (edit_idx_r != commit_idx_r) begin
                // scan back; result is issued when the scan stops
                ra            = slot(edit_dec);
                erase_nxt     = '0;
                out_valid_nxt = 1'b0;
                state_nxt     = ST_KILL;
              end
            end
            CMD_ERASE: begin
              if (edit_idx_r != commit_idx_r) begin
                edit_idx_nxt        = edit_dec;
                res_nxt.erase_count = menu_r ? 8'd0 : 8'd1;
              end
            end
            CMD_TOGGLE: begin
              menu_nxt            = !menu_r;
              res_nxt.menu_active = !menu_r;
            end
            CMD_CHAR: begin
              if (menu_r) begin
                if (head.is_w) begin
                  sel_nxt = sel_r - 2'd1;
                end else if (head.is_s) begin
                  sel_nxt = sel_r + 2'd1;
                end
                res_nxt.menu_row = sel_nxt;
              end else if (!head.is_zero &&
                           pos_dist(edit_idx_r, read_idx_r) < DEPTH_V) begin
                we                 = 1'b1;
                edit_idx_nxt       = edit_inc;
                res_nxt.echo_char  = head.char_code;
                res_nxt.echo_valid = 1'b1;
                if (head.is_commit || pos_dist(edit_inc, read_idx_r) == DEPTH_V) begin
                  commit_idx_nxt      = edit_inc;
                  res_nxt.wake_reader = 1'b1;
                end
              end
            end
            CMD_READ: begin
              if (read_idx_r == commit_idx_r) begin
                res_nxt.read_empty = 1'b1;
              end else begin
                ra            = slot(read_idx_r);
                started_nxt   = head.started;
                out_valid_nxt = 1'b0;
                state_nxt     = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_READ: begin
        res_nxt             = '0;
        res_nxt.menu_active = menu_r;
        res_nxt.menu_row    = sel_r;
        out_valid_nxt       = 1'b1;
        state_nxt           = ST_IDLE;
        if (rd_data_r == KEY_CTRL_D) begin
          res_nxt.read_eof = 1'b1;
          if (!started_r) begin
            read_idx_nxt = pos_inc(read_idx_r);
          end
        end else begin
          read_idx_nxt       = pos_inc(read_idx_r);
          res_nxt.read_char  = rd_data_r;
          res_nxt.read_valid = 1'b1;
        end
      end

      ST_KILL: begin
        res_nxt             = '0;
        res_nxt.menu_active = menu_r;
        res_nxt.menu_row    = sel_r;
        if (rd_data_r != KEY_LF) begin
          edit_idx_nxt = edit_dec;
          erase_nxt    = erase_sat;
          if (edit_dec == commit_idx_r) begin
            res_nxt.erase_count = menu_r ? 8'd0 : erase_sat;
            out_valid_nxt       = 1'b1;
            state_nxt           = ST_IDLE;
          end else begin
            ra = slot(pos_dec(edit_dec));
          end
        end else begin
          res_nxt.erase_count = menu_r ? 8'd0 : erase_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      read_idx_r   <= '0;
      commit_idx_r <= '0;
      edit_idx_r   <= '0;
      menu_r       <= 1'b0;
      sel_r        <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      read_idx_r   <= read_idx_nxt;
      commit_idx_r <= commit_idx_nxt;
      edit_idx_r   <= edit_idx_nxt;
      menu_r       <= menu_nxt;
      sel_r        <= sel_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    started_r <= started_nxt;
    erase_r   <= erase_nxt;
    res_r     <= res_nxt;
  end

  // ring: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      ring_r[wa] <= wd;
    end
    rd_data_r <= ring_r[ra];
  end

endmodule

>>> design/console_line_edit_buffer_unit.sv
// ----------------------------------------------------------------------------
// console_line_edit_buffer_unit: keyboard line-editing ring buffer
// Stream wrapper around the intake, command queue and execution back end.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake. in_tuser = 0 is a key arrival
//           (in_tdata[7:0] key code), 1 is a reader pop (in_tdata[8] says
//           the read call already took characters).
//   out_* : exactly one result per request, in request order.
// Flow: a request is written into the queue on its accept edge; the back end
//   pops it from the queue head and registers the result. A reader pop that
//   finds data adds the registered ring read (ST_READ) before its result.
//   Ctrl-U scans back one entry per cycle and stops at the commit point or
//   at an LF. Throughput: one request per cycle for keys while out_tready is
//   high; a reader pop or a Ctrl-U scan holds the back end until its result
//   is issued, bounded by the single ring read port and the back-end sequencer.
// Reset: rst_n low for one clock empties the ring indices, clears menu
//   mode and the queue; no clearing pass over the ring is needed.
// Stall: a held result keeps the back end waiting; the two-entry queue
//   keeps taking requests until it fills, then in_tready drops.
// ----------------------------------------------------------------------------
module console_line_edit_buffer_unit
  import cleb_pkg::*;
#(
  parameter int BUF_DEPTH = DEFAULT_BUF_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // key_code[7:0], read_started[8], zero pad
  input  logic                  in_tuser,   // op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // echo_char[7:0], echo_valid[8], erase_count[16:9], wake_reader[17],
  // dump_request[18], read_char[26:19], read_valid[27], read_eof[28],
  // read_empty[29], menu_active[30], menu_row[32:31], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int PAD_W = OUT_DATA_W - $bits(res_t);

  q_stat_t q_stat;
  logic    push;
  cmd_t    push_cmd;
  cmd_t    head;
  logic    pop;
  res_t    res;

  // front: handshake and key decode
  cleb_front u_front (
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // queue between the two halves
  cleb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  // back: ring, indices, kill scan, result register
  cleb_back #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .head     (head),
    .pop      (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  assign out_tdata = {{PAD_W{1'b0}}, res};

`ifndef SYNTHESIS
  // a result comes from one request class only
  a_one_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0({out_tdata[8], out_tdata[27], out_tdata[28], out_tdata[29]}))
    else $error("result mixes key and read outcomes");

  // a commit only happens on a stored, echoed key
  a_wake_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[17]) |-> out_tdata[8])
    else $error("wake without stored key");

  // menu mode suppresses echo and erase reporting
  a_menu_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[30]) |-> (!out_tdata[8] && out_tdata[16:9] == 8'd0))
    else $error("echo or erase reported in menu mode");

  // queue is empty right after reset, so intake must be open
  a_ready_after_reset: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> in_tready)
    else $error("intake closed after reset");
`endif

endmodule
